[design/fmbq_pkg.sv]
// fmbq_pkg: shared types and codes for the front/middle/back queue
// operation and status codes, controller command and datapath status structs
// no dependencies
package fmbq_pkg;

    // operation codes of a request
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_MID   = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_POP_MID    = 3'd4;
    localparam logic [2:0] ACT_POP_BACK   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture a request and work out positions
        logic rd_up;    // read at pointer, move entry one place up
        logic rd_dn;    // read at pointer, move entry one place down
        logic wr_push;  // write the pushed word at its position
        logic finish;   // update count and load the result register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic push_go;     // push that fits
        logic pop_go;      // pop from a non-empty store
        logic need_shift;  // push position lies below the back
        logic last_up;     // upward shift reads its final entry now
        logic last_dn;     // downward shift reads its final entry now
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

[design/fmbq_ram.sv]
// fmbq_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/fmbq_ctrl.sv]
// fmbq_ctrl: controller state machine sequencing one request at a time
// depends on fmbq_pkg (cmd_t, sts_t)
module fmbq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fmbq_pkg::sts_t sts,
    output fmbq_pkg::cmd_t cmd
);
    import fmbq_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        EXEC,
        SHIFT_UP,
        SHIFT_DN,
        DRAIN,
        WR_PUSH,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next = EXEC;
                end
            end
            EXEC: begin
                if (sts.push_go) begin
                    state_next = sts.need_shift ? SHIFT_UP : WR_PUSH;
                end else if (sts.pop_go) begin
                    state_next = SHIFT_DN;
                end else begin
                    state_next = FINISH;
                end
            end
            SHIFT_UP: begin
                if (sts.last_up) begin
                    state_next = DRAIN;
                end
            end
            SHIFT_DN: begin
                if (sts.last_dn) begin
                    state_next = DRAIN;
                end
            end
            DRAIN: begin
                state_next = sts.push_go ? WR_PUSH : FINISH;
            end
            WR_PUSH: begin
                state_next = FINISH;
            end
            FINISH: begin
                if (sts.out_free) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    always_comb begin
        cmd         = '0;
        cmd.load    = (state_reg == IDLE) && s_valid;
        cmd.rd_up   = (state_reg == SHIFT_UP);
        cmd.rd_dn   = (state_reg == SHIFT_DN);
        cmd.wr_push = (state_reg == WR_PUSH);
        cmd.finish  = (state_reg == FINISH) && sts.out_free;
    end

    assign s_ready = (state_reg == IDLE);

endmodule

[design/fmbq_dp.sv]
// fmbq_dp: datapath with entry RAM, count, pointers, shift pipeline and result register
// depends on fmbq_pkg and fmbq_ram
module fmbq_dp #(
    parameter int DEPTH = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fmbq_pkg::cmd_t     cmd,
    output fmbq_pkg::sts_t     sts,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pop_value,
    output logic [1:0]         m_status,
    output logic [7:0]         m_entry_count
);
    import fmbq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]    action_reg;
    logic [31:0]   push_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] ptr_reg;
    logic [31:0]   pop_word_reg;
    logic          tag_vld_reg;
    logic          tag_cap_reg;
    logic [AW-1:0] tag_dst_reg;
    logic          m_valid_reg;
    logic [31:0]   m_pop_value_reg;
    logic [1:0]    m_status_reg;
    logic [7:0]    m_entry_count_reg;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_next;
    logic [CW+7:0] count_ext;
    logic [CW-1:0] s_pos;
    logic          s_is_push;
    logic          is_push;
    logic          is_pop;
    logic          full;
    logic          empty;
    logic          wb_wr;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic [31:0]   ram_rd_data;

    // decode of the held request
    assign is_push  = (action_reg == ACT_PUSH_FRONT) || (action_reg == ACT_PUSH_MID)
                   || (action_reg == ACT_PUSH_BACK);
    assign is_pop   = (action_reg == ACT_POP_FRONT) || (action_reg == ACT_POP_MID)
                   || (action_reg == ACT_POP_BACK);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CW'(1);

    // status towards the controller
    always_comb begin
        sts            = '0;
        sts.push_go    = is_push && !full;
        sts.pop_go     = is_pop && !empty;
        sts.need_shift = (CW'(pos_reg) != count_reg);
        sts.last_up    = (ptr_reg == pos_reg);
        sts.last_dn    = (ptr_reg == count_m1[AW-1:0]);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // position of the incoming request
    assign s_is_push = (s_action == ACT_PUSH_FRONT) || (s_action == ACT_PUSH_MID)
                    || (s_action == ACT_PUSH_BACK);
    always_comb begin
        case (s_action)
            ACT_PUSH_MID:  s_pos = count_reg >> 1;
            ACT_PUSH_BACK: s_pos = count_reg;
            ACT_POP_MID:   s_pos = count_m1 >> 1;
            ACT_POP_BACK:  s_pos = count_m1;
            default:       s_pos = '0;
        endcase
    end

    // request capture and shift pointer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            push_reg   <= s_push_value;
            pos_reg    <= s_pos[AW-1:0];
            ptr_reg    <= s_is_push ? count_m1[AW-1:0] : s_pos[AW-1:0];
        end else if (cmd.rd_up) begin
            ptr_reg <= ptr_reg - AW'(1);
        end else if (cmd.rd_dn) begin
            ptr_reg <= ptr_reg + AW'(1);
        end
    end

    // read tag: where the word read this cycle goes next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_vld_reg <= 1'b0;
        end else begin
            tag_vld_reg <= cmd.rd_up || cmd.rd_dn;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_up) begin
            tag_cap_reg <= 1'b0;
            tag_dst_reg <= ptr_reg + AW'(1);
        end else if (cmd.rd_dn) begin
            tag_cap_reg <= (ptr_reg == pos_reg);
            tag_dst_reg <= ptr_reg - AW'(1);
        end
    end

    // removed word is the first read of a downward shift
    always_ff @(posedge aclk) begin
        if (tag_vld_reg && tag_cap_reg) begin
            pop_word_reg <= ram_rd_data;
        end
    end

    // write port: shift write-back or pushed word
    assign wb_wr       = tag_vld_reg && !tag_cap_reg;
    assign ram_wr_en   = wb_wr || cmd.wr_push;
    assign ram_wr_addr = wb_wr ? tag_dst_reg : pos_reg;
    assign ram_wr_data = wb_wr ? ram_rd_data : push_reg;

    fmbq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_up || cmd.rd_dn),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    // count after the operation
    always_comb begin
        if (sts.push_go) begin
            count_next = count_reg + CW'(1);
        end else if (sts.pop_go) begin
            count_next = count_m1;
        end else begin
            count_next = count_reg;
        end
    end
    assign count_ext = {8'b0, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.finish) begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_entry_count_reg <= count_ext[7:0];
            if (is_push && full) begin
                m_status_reg    <= ST_FULL;
                m_pop_value_reg <= '0;
            end else if (is_pop && empty) begin
                m_status_reg    <= ST_EMPTY;
                m_pop_value_reg <= '1;
            end else begin
                m_status_reg    <= ST_OK;
                m_pop_value_reg <= sts.pop_go ? pop_word_reg : '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pop_value   = m_pop_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

[design/front_middle_back_queue_core.sv]
// front/middle/back queue: one request at a time
// a push at the back writes its word directly, other pushes first shift entries up, pops
// read the removed entry and shift the rest down, rejected or unused codes go to the result
// next request accepted the cycle after the result is loaded; the shift moves one
// entry per cycle through the single write port of the entry RAM
// reset (aresetn, synchronous, active low) empties the queue; RAM contents are not cleared
module front_middle_back_queue_core #(
    parameter int DEPTH = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pop_value,
    output logic [1:0]         m_status,
    output logic [7:0]         m_entry_count
);
    import fmbq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    fmbq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and result
    fmbq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_action      (s_action),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

endmodule

[design/fmbq_checker.sv]
// fmbq_sva: port-level assertions for the queue core, bound to the top level
// depends on fmbq_pkg (status codes)
module fmbq_sva #(
    parameter int DEPTH = 128
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pop_value,
    input logic [1:0]         m_status,
    input logic [7:0]         m_entry_count
);
    import fmbq_pkg::*;

    localparam logic [7:0] FULL_CNT = 8'(DEPTH);

    // one request in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pop_value) && $stable(m_status)
            && $stable(m_entry_count))
        else $error("stalled result changed");

    // an empty pop reports minus one and an empty store
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_pop_value == -32'sd1)
            && (m_entry_count == 8'd0))
        else $error("empty pop result inconsistent");

    // a dropped push reports zero and a full store
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_pop_value == 32'sd0)
            && (m_entry_count == FULL_CNT))
        else $error("dropped push result inconsistent");

endmodule

bind front_middle_back_queue_core fmbq_sva #(.DEPTH(DEPTH)) u_fmbq_sva (.*);
